@@ sv/tun_pkg.sv @@
// Package for the triangle unit normal block: widths and payload structs.
// Used by tun_cross, tun_divide and the top level; depends on nothing.
package tun_pkg;

    localparam int COORD_WIDTH_DEF      = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 14;
    localparam int FIELD_WIDTH          = 16;
    localparam int NORMAL_WIDTH         = 16;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] vertex0_x;
        logic signed [FIELD_WIDTH-1:0] vertex0_y;
        logic signed [FIELD_WIDTH-1:0] vertex0_z;
        logic signed [FIELD_WIDTH-1:0] vertex1_x;
        logic signed [FIELD_WIDTH-1:0] vertex1_y;
        logic signed [FIELD_WIDTH-1:0] vertex1_z;
        logic signed [FIELD_WIDTH-1:0] vertex2_x;
        logic signed [FIELD_WIDTH-1:0] vertex2_y;
        logic signed [FIELD_WIDTH-1:0] vertex2_z;
    } tri_in_t;

    typedef struct packed {
        logic signed [NORMAL_WIDTH-1:0] normal_x;
        logic signed [NORMAL_WIDTH-1:0] normal_y;
        logic signed [NORMAL_WIDTH-1:0] normal_z;
        logic                           degenerate;
    } tri_out_t;

endpackage

@@ sv/tun_cross.sv @@
// Front stages: sign extension, edge subtraction, registered products, cross product,
// magnitudes and sum of squares. Depends on tun_pkg.
module tun_cross #(
    parameter int COORD_WIDTH = tun_pkg::COORD_WIDTH_DEF,
    parameter int CW          = 2 * COORD_WIDTH + 3,
    parameter int SW          = 2 * CW + 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  tun_pkg::tri_in_t     in_data,
    output logic                 out_valid,
    output logic [CW-2:0]        mag_x,
    output logic [CW-2:0]        mag_y,
    output logic [CW-2:0]        mag_z,
    output logic [2:0]           neg,
    output logic [SW-1:0]        sum_sq
);
    localparam int EW = COORD_WIDTH + 1;
    localparam int PW = 2 * EW;
    localparam int MW = CW - 1;

    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [PW-1:0] p_reg [6];
    logic signed [CW-1:0] c [3];
    logic [MW-1:0]        m_reg [3];
    logic [2:0]           n_reg;
    logic [2*MW-1:0]      sq_reg [3];
    logic [MW-1:0]        mm_reg [3];
    logic [2:0]           nn_reg;
    logic [4:0]           v_reg;
    logic signed [COORD_WIDTH-1:0] v [9];

    // The field bits are taken as they are; the low COORD_WIDTH bits form the coordinate.
    always_comb
    begin
        v[0] = COORD_WIDTH'($unsigned(in_data.vertex0_x));
        v[1] = COORD_WIDTH'($unsigned(in_data.vertex0_y));
        v[2] = COORD_WIDTH'($unsigned(in_data.vertex0_z));
        v[3] = COORD_WIDTH'($unsigned(in_data.vertex1_x));
        v[4] = COORD_WIDTH'($unsigned(in_data.vertex1_y));
        v[5] = COORD_WIDTH'($unsigned(in_data.vertex1_z));
        v[6] = COORD_WIDTH'($unsigned(in_data.vertex2_x));
        v[7] = COORD_WIDTH'($unsigned(in_data.vertex2_y));
        v[8] = COORD_WIDTH'($unsigned(in_data.vertex2_z));
        c[0] = CW'(p_reg[0]) - CW'(p_reg[1]);
        c[1] = CW'(p_reg[2]) - CW'(p_reg[3]);
        c[2] = CW'(p_reg[4]) - CW'(p_reg[5]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= EW'(v[3+i]) - EW'(v[i]);
                e2_reg[i] <= EW'(v[6+i]) - EW'(v[i]);
            end
            p_reg[0] <= e1_reg[1] * e2_reg[2];
            p_reg[1] <= e1_reg[2] * e2_reg[1];
            p_reg[2] <= e1_reg[2] * e2_reg[0];
            p_reg[3] <= e1_reg[0] * e2_reg[2];
            p_reg[4] <= e1_reg[0] * e2_reg[1];
            p_reg[5] <= e1_reg[1] * e2_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                n_reg[i] <= c[i][CW-1];
                m_reg[i] <= c[i][CW-1] ? MW'(-c[i]) : MW'(c[i]);
                sq_reg[i] <= m_reg[i] * m_reg[i];
                mm_reg[i] <= m_reg[i];
            end
            nn_reg <= n_reg;
            sum_sq <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
            mag_x  <= mm_reg[0];
            mag_y  <= mm_reg[1];
            mag_z  <= mm_reg[2];
            neg    <= nn_reg;
        end
    end

    assign out_valid = v_reg[4];
endmodule

@@ sv/tun_isqrt.sv @@
// Pipelined integer square root, one result bit per stage, carrying side data.
// Depends on nothing outside itself.
module tun_isqrt #(
    parameter int SW = 72,
    parameter int DW = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SW-1:0]     in_sum,
    input  logic [DW-1:0]     in_side,
    output logic              out_valid,
    output logic [SW/2-1:0]   out_root,
    output logic [DW-1:0]     out_side
);
    localparam int RW = SW / 2;
    localparam int XW = SW + 2;

    logic [SW-1:0]   rem_reg  [RW+1];
    logic [RW-1:0]   root_reg [RW+1];
    logic [DW-1:0]   side_reg [RW+1];
    logic [RW:0]     v_reg;

    always_comb
    begin
        rem_reg[0]  = in_sum;
        root_reg[0] = '0;
        side_reg[0] = in_side;
        v_reg[0]    = in_valid;
    end

    // Digit-by-digit restoring root: remainder = sum - root^2 is kept exact.
    for (genvar k = 0; k < RW; k++)
    begin : g_step
        localparam int B = RW - 1 - k;
        logic [XW-1:0] trial;
        assign trial = (XW'(root_reg[k]) << (B + 1)) + (XW'(1) << (2 * B));
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k+1] <= side_reg[k];
                if (trial <= XW'(rem_reg[k]))
                begin
                    rem_reg[k+1]  <= rem_reg[k] - SW'(trial);
                    root_reg[k+1] <= root_reg[k] | (RW'(1) << B);
                end
                else
                begin
                    rem_reg[k+1]  <= rem_reg[k];
                    root_reg[k+1] <= root_reg[k];
                end
            end
        end
    end

    assign out_valid = v_reg[RW];
    assign out_root  = root_reg[RW];
    assign out_side  = side_reg[RW];
endmodule

@@ sv/tun_divide.sv @@
// Pipelined restoring divider for the three components by the common length.
// Depends on tun_pkg.
module tun_divide #(
    parameter int MW = 34,
    parameter int LW = 36,
    parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [MW-1:0]          mag [3],
    input  logic [2:0]             neg,
    input  logic [LW-1:0]          len,
    output logic                   out_valid,
    output tun_pkg::tri_out_t      out_data
);
    localparam int NW = tun_pkg::NORMAL_WIDTH;
    localparam int QW = NORMAL_FRAC_BITS + 1;
    localparam int DW = MW + NORMAL_FRAC_BITS;
    localparam int RW = LW + 1;

    // |c| <= len, so the quotient fits in QW bits: only QW quotient steps are needed.
    logic [DW-1:0] num_reg [QW+1][3];
    logic [RW-1:0] rem_reg [QW+1][3];
    logic [QW-1:0] q_reg   [QW+1][3];
    logic [LW-1:0] d_reg   [QW+1];
    logic [2:0]    n_reg   [QW+1];
    logic [QW:0]   v_reg;

    // The bits of the scaled numerator above the QW quotient steps form the
    // starting remainder, which is already below the length.
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            num_reg[0][j] = DW'(mag[j]) << NORMAL_FRAC_BITS;
            rem_reg[0][j] = RW'(num_reg[0][j] >> QW);
            q_reg[0][j]   = '0;
        end
        d_reg[0] = len;
        n_reg[0] = neg;
        v_reg[0] = in_valid;
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        localparam int B = QW - 1 - k;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[k+1] <= d_reg[k];
                n_reg[k+1] <= n_reg[k];
                for (int j = 0; j < 3; j++)
                begin
                    num_reg[k+1][j] <= num_reg[k][j];
                    if ({rem_reg[k][j][RW-2:0], num_reg[k][j][B]} >= RW'(d_reg[k]))
                    begin
                        rem_reg[k+1][j] <= {rem_reg[k][j][RW-2:0], num_reg[k][j][B]}
                                           - RW'(d_reg[k]);
                        q_reg[k+1][j]   <= q_reg[k][j] | (QW'(1) << B);
                    end
                    else
                    begin
                        rem_reg[k+1][j] <= {rem_reg[k][j][RW-2:0], num_reg[k][j][B]};
                        q_reg[k+1][j]   <= q_reg[k][j];
                    end
                end
            end
        end
    end

    logic [NW-1:0] qn [3];
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            qn[j] = NW'(q_reg[QW][j]);
            if (n_reg[QW][j])
            begin
                qn[j] = -qn[j];
            end
        end
    end

    // A zero length only comes with zero magnitudes, and the quotient is then
    // meaningless; flag it and force zeros.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= v_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data.degenerate <= (d_reg[QW] == '0);
            out_data.normal_x   <= (d_reg[QW] == '0) ? '0 : qn[0];
            out_data.normal_y   <= (d_reg[QW] == '0) ? '0 : qn[1];
            out_data.normal_z   <= (d_reg[QW] == '0) ? '0 : qn[2];
        end
    end
endmodule

@@ sv/triangle_unit_normal.sv @@
// Top level of the triangle unit normal block: pipeline, stall control, output skid.
// Depends on tun_pkg, tun_cross, tun_isqrt and tun_divide.
//
// Usage: a triangle (three vertices, signed Q8.8) arrives on the in channel as one
// transaction of type tri_in_t under in_valid/in_ready. The unit normal in signed
// Q1.14 and a degenerate flag leave on the out channel as one tri_out_t transaction
// under out_valid/out_ready. Each input transaction gives exactly one output.
// Throughput is one triangle per cycle while in_ready is high. There are 5 register
// stages for the cross product and sum of squares, one per root bit (2*COORD_WIDTH+4),
// NORMAL_FRAC_BITS + 2 in the divider and one in the output buffer. The accepting edge
// loads the first stage.
// The length is the bit-by-bit root pipeline; the quotient is a restoring divider
// pipeline with one bit per stage, run for all three components side by side.
// Reset clears every valid bit; data registers are not reset.
// When the receiver stalls, results collect in a two-entry skid buffer at the output;
// once it holds two, the whole pipeline freezes in place and in_ready drops, so
// nothing is lost or repeated.
module triangle_unit_normal #(
    parameter int COORD_WIDTH      = tun_pkg::COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tun_pkg::tri_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tun_pkg::tri_out_t out_data
);
    localparam int CW = 2 * COORD_WIDTH + 3;
    localparam int MW = CW - 1;
    localparam int SW = 2 * CW + 2;
    localparam int LW = SW / 2;

    logic              en;
    logic              cr_valid;
    logic [MW-1:0]     mag [3];
    logic [2:0]        neg;
    logic [SW-1:0]     sum_sq;
    logic              sq_valid;
    logic [LW-1:0]     root;
    logic [3*MW+2:0]   side;
    logic              dv_valid;
    tun_pkg::tri_out_t dv_data;

    // The pipeline advances whenever the skid buffer has room for one more result.
    logic [1:0]        cnt_reg;
    tun_pkg::tri_out_t buf_reg [2];

    assign en       = (cnt_reg != 2'd2);
    assign in_ready = en;

    tun_cross #(.COORD_WIDTH(COORD_WIDTH), .CW(CW), .SW(SW)) u_cross (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(in_valid), .in_data(in_data),
        .out_valid(cr_valid), .mag_x(mag[0]), .mag_y(mag[1]), .mag_z(mag[2]),
        .neg(neg), .sum_sq(sum_sq)
    );

    tun_isqrt #(.SW(SW), .DW(3 * MW + 3)) u_isqrt (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(cr_valid), .in_sum(sum_sq), .in_side({mag[0], mag[1], mag[2], neg}),
        .out_valid(sq_valid), .out_root(root), .out_side(side)
    );

    logic [MW-1:0] dmag [3];
    assign dmag[0] = side[3*MW+2:2*MW+3];
    assign dmag[1] = side[2*MW+2:MW+3];
    assign dmag[2] = side[MW+2:3];

    tun_divide #(.MW(MW), .LW(LW), .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_divide (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(sq_valid), .mag(dmag), .neg(side[2:0]), .len(root),
        .out_valid(dv_valid), .out_data(dv_data)
    );

    // Output FIFO of depth two; entry zero is the head.
    logic        push;
    logic        pop;
    logic        to_head;
    logic [1:0]  cnt_next;
    assign push     = en && dv_valid;
    assign pop      = out_valid && out_ready;
    assign to_head  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop);
    assign cnt_next = cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && to_head)
        begin
            buf_reg[0] <= dv_data;
        end
        else if (pop)
        begin
            buf_reg[0] <= buf_reg[1];
        end
        if (push && !to_head)
        begin
            buf_reg[1] <= dv_data;
        end
    end

    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = buf_reg[0];
endmodule
